// ===== src/vdag_pkg.sv =====
// shared constants and types of the voxel dag node packer
// no dependencies; every other file but vdag_ram imports this package
`default_nettype none

package vdag_pkg;

  localparam int MAX_NODES   = 65536;
  localparam int CHILD_COUNT = 8;

  localparam int MASK_W = 8;
  localparam int IDX_W  = 16;
  localparam int WORD_W = 32;
  localparam int OFF_W  = 20;

  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int ADDR_W    = NODE_W + 1;
  localparam int MAP_DEPTH = 2 ** ADDR_W;
  localparam int EXT_W     = IDX_W + NODE_W;

  // one node as held by the word sequencer
  typedef struct packed {
    logic [MASK_W-1:0]                  mask;
    logic [CHILD_COUNT-1:0][IDX_W-1:0]  idx;
    logic                               leaf;
    logic                               ovf;
    logic                               rec;
    logic [ADDR_W-1:0]                  wr_addr;
    logic [OFF_W-1:0]                   base;
    logic                               rd_bank;
  } node_t;

  // what one child lane hands to the merge
  typedef struct packed {
    logic               sel;
    logic               use_ram;
    logic [ADDR_W-1:0]  addr;
    logic [WORD_W-1:0]  word;
  } lane_t;

  // one output word before the map lookup data is folded in
  typedef struct packed {
    logic               use_ram;
    logic [WORD_W-1:0]  word;
    logic [OFF_W-1:0]   offset;
    logic               last;
    logic               ovf;
  } tok_t;

endpackage

`default_nettype wire

// ===== src/vdag_if.sv =====
// valid/ready channel interfaces for node input and packed word output
// depends on vdag_pkg
`default_nettype none

interface vdag_in_if import vdag_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MASK_W-1:0]  child_present;
  logic [IDX_W-1:0]   child_index_0;
  logic [IDX_W-1:0]   child_index_1;
  logic [IDX_W-1:0]   child_index_2;
  logic [IDX_W-1:0]   child_index_3;
  logic [IDX_W-1:0]   child_index_4;
  logic [IDX_W-1:0]   child_index_5;
  logic [IDX_W-1:0]   child_index_6;
  logic [IDX_W-1:0]   child_index_7;
  logic               starts_level;
  logic               leaf_children;

  modport source (
    output valid, child_present, child_index_0, child_index_1, child_index_2,
           child_index_3, child_index_4, child_index_5, child_index_6,
           child_index_7, starts_level, leaf_children,
    input  ready
  );
  modport sink (
    input  valid, child_present, child_index_0, child_index_1, child_index_2,
           child_index_3, child_index_4, child_index_5, child_index_6,
           child_index_7, starts_level, leaf_children,
    output ready
  );
endinterface

interface vdag_out_if import vdag_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  packed_word;
  logic [OFF_W-1:0]   word_offset;
  logic               last_word;
  logic               overflow;

  modport source (
    output valid, packed_word, word_offset, last_word, overflow,
    input  ready
  );
  modport sink (
    input  valid, packed_word, word_offset, last_word, overflow,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/voxel_dag_node_packer.sv =====
// voxel dag node packer top level: node input, level counters, output word register
// depends on vdag_pkg, vdag_if, vdag_seq
//
// in_i carries one octree node per word: child mask, eight child indices,
// a new-level flag and a subgrid flag. out_o carries packed words: the child mask,
// then one word per present child in ascending order (mapped offset, or the index
// for leaf children), each with its level-array offset, last flag and overflow flag.
// A node emits 1 + popcount(child_present) words, from 1 to 9, all through the
// single output word stream.
// A node is taken when the sequencer is free; its first word passes the node buffer
// and then the output register, and a new node is taken in the cycle its predecessor
// sends its last word, so words leave back to back.
// Node start offsets are kept in a two-bank map ram of 2 x MAX_NODES entries
// with one write and one read port; the map is not cleared, and reset only clears the
// bank select, the word and node counters and the valid, mask-done and pending state.
// When out_o stalls, the output register holds its word and the sequencer,
// and then in_i.ready, wait; nothing is dropped.
`default_nettype none

module voxel_dag_node_packer import vdag_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  vdag_in_if.sink     in_i,
  vdag_out_if.source  out_o
);

  logic               bank_q, bank_d;
  logic [OFF_W-1:0]   wc_q, wc_d;
  logic [CNT_W-1:0]   nc_q, nc_d;

  logic               in_fire;
  logic               take;
  node_t              node;
  logic [OFF_W-1:0]   wc_cur;
  logic [CNT_W-1:0]   nc_cur;

  logic               tok_valid;
  tok_t               tok;
  logic [OFF_W-1:0]   rdata;

  logic               s2_valid_q, s2_valid_d;
  tok_t               s2_q;
  logic               s2_free;

  assign in_fire    = in_i.valid && take;
  assign in_i.ready = take;

  always_comb begin
    bank_d = bank_q ^ in_i.starts_level;
    wc_cur = in_i.starts_level ? '0 : wc_q;
    nc_cur = in_i.starts_level ? '0 : nc_q;

    node         = '0;
    node.mask    = in_i.child_present;
    node.idx[0]  = in_i.child_index_0;
    node.idx[1]  = in_i.child_index_1;
    node.idx[2]  = in_i.child_index_2;
    node.idx[3]  = in_i.child_index_3;
    node.idx[4]  = in_i.child_index_4;
    node.idx[5]  = in_i.child_index_5;
    node.idx[6]  = in_i.child_index_6;
    node.idx[7]  = in_i.child_index_7;
    node.leaf    = in_i.leaf_children;
    node.rd_bank = !bank_d;
    node.base    = wc_cur;
    node.wr_addr = {bank_d, nc_cur[NODE_W-1:0]};

    if (nc_cur < CNT_W'(MAX_NODES)) begin
      node.rec = 1'b1;
      node.ovf = 1'b0;
      nc_d     = nc_cur + 1'b1;
    end else begin
      node.rec = 1'b0;
      node.ovf = 1'b1;
      nc_d     = CNT_W'(MAX_NODES);
    end

    wc_d = wc_cur + OFF_W'(1) + OFF_W'($countones(in_i.child_present));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= 1'b0;
      wc_q   <= '0;
      nc_q   <= '0;
    end else if (in_fire) begin
      bank_q <= bank_d;
      wc_q   <= wc_d;
      nc_q   <= nc_d;
    end
  end

  vdag_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_fire),
    .node_i      (node),
    .tok_ready_i (s2_free),
    .take_o      (take),
    .tok_valid_o (tok_valid),
    .tok_o       (tok),
    .rdata_o     (rdata)
  );

  assign s2_free = !s2_valid_q || out_o.ready;

  always_comb begin
    s2_valid_d = s2_valid_q;
    if (s2_free) begin
      s2_valid_d = tok_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free && tok_valid) begin
      s2_q <= tok;
    end
  end

  assign out_o.valid       = s2_valid_q;
  assign out_o.packed_word = s2_q.use_ram ? WORD_W'(rdata) : s2_q.word;
  assign out_o.word_offset = s2_q.offset;
  assign out_o.last_word   = s2_q.last;
  assign out_o.overflow    = s2_q.ovf;

  // node ordinal advances by one within a level below capacity
  a_node_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !in_i.starts_level && (nc_q < CNT_W'(MAX_NODES)))
      |=> (nc_q == CNT_W'($past(nc_q) + 1'b1)))
    else $error("node ordinal did not advance");

  // word counter moves by the node's word count within a level
  a_word_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !in_i.starts_level)
      |=> (wc_q == OFF_W'($past(wc_q) + OFF_W'(1)
                          + OFF_W'($countones($past(in_i.child_present))))))
    else $error("word counter out of step");

  // a new level swaps the map banks
  a_bank_swap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.starts_level) |=> (bank_q != $past(bank_q)))
    else $error("bank select did not toggle");

endmodule

`default_nettype wire

// ===== src/vdag_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module vdag_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [$clog2(DEPTH)-1:0]  waddr_i,
  input  logic [WIDTH-1:0]          wdata_i,
  input  logic                      re_i,
  input  logic [$clog2(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/vdag_lane.sv =====
// one child lane: pick test, range check and map address for one child
// depends on vdag_pkg
`default_nettype none

module vdag_lane import vdag_pkg::*; (
  input  logic              pend_i,
  input  logic              below_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  logic              leaf_i,
  input  logic              rd_bank_i,
  output logic              below_o,
  output lane_t             lane_o
);

  logic [EXT_W-1:0] idx_ext;
  logic             sel;
  logic             in_range;

  assign idx_ext  = EXT_W'(idx_i);
  assign in_range = idx_ext < EXT_W'(MAX_NODES);
  assign sel      = pend_i && !below_i;
  assign below_o  = below_i || pend_i;

  always_comb begin
    lane_o = '0;
    if (sel) begin
      lane_o.sel     = 1'b1;
      lane_o.use_ram = !leaf_i && in_range;
      lane_o.addr    = {rd_bank_i, idx_ext[NODE_W-1:0]};
      lane_o.word    = leaf_i ? WORD_W'(idx_i) : '0;
    end
  end

endmodule

`default_nettype wire

// ===== src/vdag_seq.sv =====
// word sequencer: node buffer, child lanes, lane merge and offset map ram
// depends on vdag_pkg, vdag_lane, vdag_ram
`default_nettype none

module vdag_seq import vdag_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  node_t              node_i,
  input  logic               tok_ready_i,
  output logic               take_o,
  output logic               tok_valid_o,
  output tok_t               tok_o,
  output logic [OFF_W-1:0]   rdata_o
);

  node_t                   node_q;
  logic                    node_valid_q, node_valid_d;
  logic                    mask_done_q, mask_done_d;
  logic [CHILD_COUNT-1:0]  pend_q, pend_d;
  logic [OFF_W-1:0]        off_q, off_d;

  logic                    below [CHILD_COUNT+1];
  lane_t                   lanes [CHILD_COUNT];
  lane_t                   merged;
  logic [CHILD_COUNT-1:0]  sel_vec;
  logic                    tok_fire;
  logic                    ram_we;
  logic                    ram_re;

  assign below[0] = 1'b0;

  for (genvar i = 0; i < CHILD_COUNT; i++) begin : g_lane
    vdag_lane u_lane (
      .pend_i    (pend_q[i] && mask_done_q),
      .below_i   (below[i]),
      .idx_i     (node_q.idx[i]),
      .leaf_i    (node_q.leaf),
      .rd_bank_i (node_q.rd_bank),
      .below_o   (below[i+1]),
      .lane_o    (lanes[i])
    );
    assign sel_vec[i] = lanes[i].sel;
  end

  always_comb begin
    merged = '0;
    for (int i = 0; i < CHILD_COUNT; i++) begin
      merged = lane_t'(merged | lanes[i]);
    end
  end

  always_comb begin
    tok_o        = '0;
    tok_o.offset = off_q;
    tok_o.ovf    = node_q.ovf;
    if (!mask_done_q) begin
      tok_o.word = WORD_W'(node_q.mask);
      tok_o.last = (node_q.mask == '0);
    end else begin
      tok_o.word    = merged.word;
      tok_o.use_ram = merged.use_ram;
      tok_o.last    = ((pend_q & ~sel_vec) == '0);
    end
  end

  assign tok_valid_o = node_valid_q;
  assign tok_fire    = node_valid_q && tok_ready_i;
  assign take_o      = !node_valid_q || (tok_ready_i && tok_o.last);

  assign ram_we = tok_fire && !mask_done_q && node_q.rec;
  assign ram_re = tok_fire && mask_done_q && merged.use_ram;

  vdag_ram #(
    .WIDTH (OFF_W),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (node_q.wr_addr),
    .wdata_i (node_q.base),
    .re_i    (ram_re),
    .raddr_i (merged.addr),
    .rdata_o (rdata_o)
  );

  always_comb begin
    node_valid_d = node_valid_q;
    mask_done_d  = mask_done_q;
    pend_d       = pend_q;
    off_d        = off_q;
    if (load_i) begin
      node_valid_d = 1'b1;
      mask_done_d  = 1'b0;
      pend_d       = node_i.mask;
      off_d        = node_i.base;
    end else if (tok_fire) begin
      off_d       = off_q + 1'b1;
      mask_done_d = 1'b1;
      if (mask_done_q) begin
        pend_d = pend_q & ~sel_vec;
      end
      if (tok_o.last) begin
        node_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_valid_q <= 1'b0;
      mask_done_q  <= 1'b0;
      pend_q       <= '0;
    end else begin
      node_valid_q <= node_valid_d;
      mask_done_q  <= mask_done_d;
      pend_q       <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q <= off_d;
    if (load_i) begin
      node_q <= node_i;
    end
  end

  // map writes belong to the mask word of a node
  a_we_on_mask : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (tok_fire && !mask_done_q))
    else $error("map write outside mask word");

  // a node past its mask word always has a child left to send
  a_pend_left : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (node_valid_q && mask_done_q) |-> (pend_q != '0))
    else $error("sequencer holds node with no child left");

  // a lookup comes from exactly one lane
  a_one_lane : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> $onehot(sel_vec))
    else $error("lookup without a single selected lane");

endmodule

`default_nettype wire
